// File: design/oprc_pkg.sv
`timescale 1ns / 1ps
package oprc_pkg;
	localparam int ENTRIES = 8;
	localparam int SLOTS = 16;
	localparam int EW = $clog2(ENTRIES);
	localparam int SW = $clog2(SLOTS);
	localparam int CW = $clog2(SLOTS + 1);

	localparam logic [1:0] ACT_STORE   = 2'd0;
	localparam logic [1:0] ACT_FIND    = 2'd1;
	localparam logic [1:0] ACT_PIN     = 2'd2;
	localparam logic [1:0] ACT_COLLECT = 2'd3;

	typedef struct packed {
		logic [1:0]  action;
		logic [63:0] w0;
		logic [63:0] w1;
		logic [63:0] w2;
		logic [63:0] w3;
		logic [31:0] len;
		logic [15:0] total;
		logic [15:0] slot;
		logic        pkt_ok;
		logic [63:0] tick;
		logic        pin;
		logic [7:0]  limit;
	} req_t;

	typedef struct packed {
		logic load;
		logic lookup;
		logic apply;
		logic scan;
		logic evict;
		logic clr_out;
	} cmd_t;

	typedef struct packed {
		logic best_ok;
		logic limit_reached;
		logic limit_zero;
	} sts_t;

	typedef struct packed {
		logic        ok;
		logic [2:0]  entry_no;
		logic [6:0]  slot_address;
		logic [4:0]  accepted_count;
		logic [4:0]  packet_total_out;
		logic [31:0] object_length_out;
		logic        complete;
		logic        pinned_out;
		logic [63:0] last_tick_out;
		logic [3:0]  collected;
	} res_t;
endpackage

// File: design/oprc_ctrl.sv
`timescale 1ns / 1ps
module oprc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_fire,
	input  logic [1:0]    action,
	input  logic          out_free,
	input  oprc_pkg::sts_t sts,
	output oprc_pkg::cmd_t cmd,
	output logic          busy,
	output logic          done
);
	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_LOOK  = 6'b000010,
		S_APPLY = 6'b000100,
		S_SCAN  = 6'b001000,
		S_EVICT = 6'b010000,
		S_OUT   = 6'b100000
	} state_t;
	state_t state_q, state_d;
	logic [1:0] act_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			act_q <= oprc_pkg::ACT_STORE;
		end else begin
			state_q <= state_d;
			if (in_fire) act_q <= action;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		done = 1'b0;
		busy = (state_q != S_IDLE);
		case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					cmd.load = 1'b1;
					state_d = S_LOOK;
				end
			end
			S_LOOK: begin
				cmd.lookup = 1'b1;
				if (act_q == oprc_pkg::ACT_COLLECT) state_d = S_SCAN;
				else state_d = S_APPLY;
			end
			S_APPLY: begin
				cmd.apply = 1'b1;
				state_d = S_OUT;
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.limit_zero) begin
					cmd.clr_out = 1'b1;
					state_d = S_OUT;
				end else if (sts.limit_reached || !sts.best_ok) begin
					state_d = S_OUT;
				end else begin
					state_d = S_EVICT;
				end
			end
			S_EVICT: begin
				cmd.evict = 1'b1;
				state_d = S_SCAN;
			end
			S_OUT: begin
				if (out_free) begin
					done = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end
endmodule

// File: design/oprc_dp.sv
`timescale 1ns / 1ps
module oprc_dp (
	input  logic           clk,
	input  logic           arst_n,
	input  oprc_pkg::req_t  req,
	input  oprc_pkg::cmd_t  cmd,
	output oprc_pkg::sts_t  sts,
	output oprc_pkg::res_t  res
);
	localparam int N = oprc_pkg::ENTRIES;
	localparam int EW = oprc_pkg::EW;
	localparam int CW = oprc_pkg::CW;

	oprc_pkg::req_t r_q;
	logic [63:0] k0_q [N];
	logic [63:0] k1_q [N];
	logic [63:0] k2_q [N];
	logic [63:0] k3_q [N];
	logic [31:0] len_q [N];
	logic [CW-1:0] tot_q [N];
	logic [CW-1:0] cnt_q [N];
	logic [63:0] tick_q [N];
	logic [N-1:0] pin_q, done_q;
	logic [oprc_pkg::SLOTS-1:0] bm_q [N];

	logic [EW-1:0] e_q;
	logic hit_q, have_q;
	logic [3:0] coll_q;
	logic [EW-1:0] best;
	logic best_ok;
	logic [N-1:0] used;
	logic [N-1:0] elig, win;
	logic idz;

	assign idz = ((r_q.w0 | r_q.w1 | r_q.w2 | r_q.w3) == 64'd0);

	always_comb begin
		for (int i = 0; i < N; i++)
			used[i] = (tot_q[i] != '0) &&
				((k0_q[i] | k1_q[i] | k2_q[i] | k3_q[i]) != 64'd0);
	end

	logic [EW-1:0] hit_e, free_e;
	logic hit_v, free_v;
	always_comb begin
		hit_e = '0; hit_v = 1'b0; free_e = '0; free_v = 1'b0;
		for (int i = N - 1; i >= 0; i--) begin
			if (used[i] && k0_q[i] == r_q.w0 && k1_q[i] == r_q.w1 &&
				k2_q[i] == r_q.w2 && k3_q[i] == r_q.w3) begin
				hit_e = EW'(i); hit_v = 1'b1;
			end
			if (!used[i]) begin
				free_e = EW'(i); free_v = 1'b1;
			end
		end
		hit_v = hit_v && !idz;
	end

	// An entry is the eviction choice when no other candidate is older, or
	// equally old at a lower index.
	always_comb begin
		elig = used & ~pin_q;
		win = elig;
		for (int i = 0; i < N; i++)
			for (int j = 0; j < N; j++)
				if (elig[j] && ((j < i && tick_q[j] <= tick_q[i]) ||
					(j > i && tick_q[j] < tick_q[i])))
					win[i] = 1'b0;
		best = '0;
		for (int i = N - 1; i >= 0; i--)
			if (win[i]) best = EW'(i);
		best_ok = |elig;
	end

	logic [oprc_pkg::SLOTS-1:0] bit_m;
	logic store_bad, fresh;
	assign bit_m = oprc_pkg::SLOTS'(1) << r_q.slot[oprc_pkg::SW-1:0];
	assign fresh = (tot_q[e_q] == '0);
	always_comb begin
		store_bad = (r_q.tick == 64'd0) || !r_q.pkt_ok || idz ||
			(r_q.total > 16'(oprc_pkg::SLOTS)) || (r_q.slot >= r_q.total) || !have_q ||
			((bm_q[e_q] & bit_m) != '0) ||
			(!fresh && (len_q[e_q] != r_q.len || 16'(tot_q[e_q]) != r_q.total));
	end

	assign sts.best_ok = best_ok;
	assign sts.limit_reached = (8'(coll_q) >= r_q.limit);
	assign sts.limit_zero = (r_q.limit == 8'd0);

	logic [CW-1:0] cnt_n;
	assign cnt_n = cnt_q[e_q] + CW'(1);

	always_ff @(posedge clk) begin
		if (cmd.load) r_q <= req;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < N; i++) begin
				k0_q[i] <= '0; k1_q[i] <= '0; k2_q[i] <= '0; k3_q[i] <= '0;
				len_q[i] <= '0; tot_q[i] <= '0; cnt_q[i] <= '0; tick_q[i] <= '0;
				bm_q[i] <= '0;
			end
			pin_q <= '0; done_q <= '0;
			e_q <= '0; hit_q <= 1'b0; have_q <= 1'b0; coll_q <= '0;
			res <= '0;
		end else begin
			if (cmd.lookup) begin
				hit_q <= hit_v;
				e_q <= hit_v ? hit_e : free_e;
				have_q <= hit_v || free_v;
				coll_q <= '0;
				res <= '0;
			end
			if (cmd.apply) begin
				res <= '0;
				if (r_q.action == oprc_pkg::ACT_STORE) begin
					if (!store_bad) begin
						if (fresh) begin
							k0_q[e_q] <= r_q.w0; k1_q[e_q] <= r_q.w1;
							k2_q[e_q] <= r_q.w2; k3_q[e_q] <= r_q.w3;
							len_q[e_q] <= r_q.len;
							tot_q[e_q] <= CW'(r_q.total);
						end
						bm_q[e_q] <= bm_q[e_q] | bit_m;
						cnt_q[e_q] <= cnt_n;
						tick_q[e_q] <= r_q.tick;
						done_q[e_q] <= (cnt_n == CW'(r_q.total));
						res.ok <= 1'b1;
						res.entry_no <= 3'(e_q);
						res.slot_address <= 7'((32'(e_q) * oprc_pkg::SLOTS) + 32'(r_q.slot));
						res.accepted_count <= 5'(cnt_n);
						res.packet_total_out <= 5'(r_q.total);
						res.object_length_out <= r_q.len;
						res.complete <= (cnt_n == CW'(r_q.total));
						res.pinned_out <= pin_q[e_q];
						res.last_tick_out <= r_q.tick;
					end
				end else if (hit_q) begin
					if (r_q.action == oprc_pkg::ACT_PIN) pin_q[e_q] <= r_q.pin;
					res.ok <= 1'b1;
					res.entry_no <= 3'(e_q);
					res.accepted_count <= 5'(cnt_q[e_q]);
					res.packet_total_out <= 5'(tot_q[e_q]);
					res.object_length_out <= len_q[e_q];
					res.complete <= done_q[e_q];
					res.pinned_out <= (r_q.action == oprc_pkg::ACT_PIN) ? r_q.pin : pin_q[e_q];
					res.last_tick_out <= tick_q[e_q];
				end
			end
			if (cmd.scan && !cmd.clr_out) begin
				res.ok <= 1'b1;
				res.collected <= coll_q;
			end
			if (cmd.evict) begin
				k0_q[best] <= '0; k1_q[best] <= '0; k2_q[best] <= '0; k3_q[best] <= '0;
				len_q[best] <= '0; tot_q[best] <= '0; cnt_q[best] <= '0;
				tick_q[best] <= '0; bm_q[best] <= '0;
				pin_q[best] <= 1'b0; done_q[best] <= 1'b0;
				coll_q <= coll_q + 4'd1;
			end
		end
	end
endmodule

// File: design/object_packet_reassembly_cache.sv
`timescale 1ns / 1ps
// Packet reassembly table with eight entries keyed by a 256-bit object id.
// Requests arrive as items on the s_axis channel; each request gives exactly
// one result item on the m_axis channel.
// A request is taken only while the controller is idle. For store, find and
// set pin, the request passes through a key compare across all entries, an
// update, then presentation in the output register; the next request is
// taken only after that, so requests are handled one at a time.
// Collect repeats an oldest-entry search followed by a clear for each evicted
// entry, until the limit is reached or no unpinned entry is left.
// The result holds in an output register until m_axis_tready is high. One
// further request can be processed meanwhile; its result then waits inside
// and s_axis_tready stays low until the register is free, so a stalled
// receiver stalls the sender.
// Reset clears every entry at once; a request offered during it is lost.
module object_packet_reassembly_cache (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// action, id_word0..3, object_length, packet_total, packet_slot, packet_ok,
	// use_stamp, pin_value, collect_limit (from bit 0 up, 396 bits used)
	input  logic [399:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// ok, entry_no, slot_address, accepted_count, packet_total_out,
	// object_length_out, complete, pinned_out, last_tick_out, collected
	// (from bit 0 up, 123 bits used)
	output logic [127:0] m_axis_tdata
);
	oprc_pkg::req_t req;
	oprc_pkg::cmd_t cmd;
	oprc_pkg::sts_t sts;
	oprc_pkg::res_t res;
	logic busy, done, fire, out_vld_q;
	logic [127:0] out_q;

	assign req.action = s_axis_tdata[1:0];
	assign req.w0 = s_axis_tdata[65:2];
	assign req.w1 = s_axis_tdata[129:66];
	assign req.w2 = s_axis_tdata[193:130];
	assign req.w3 = s_axis_tdata[257:194];
	assign req.len = s_axis_tdata[289:258];
	assign req.total = s_axis_tdata[305:290];
	assign req.slot = s_axis_tdata[321:306];
	assign req.pkt_ok = s_axis_tdata[322];
	assign req.tick = s_axis_tdata[386:323];
	assign req.pin = s_axis_tdata[387];
	assign req.limit = s_axis_tdata[395:388];

	assign s_axis_tready = !busy;
	assign fire = s_axis_tvalid && s_axis_tready;

	oprc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(fire), .action(req.action),
		.out_free(!out_vld_q || m_axis_tready), .sts(sts), .cmd(cmd), .busy(busy),
		.done(done)
	);

	oprc_dp u_dp (
		.clk(clk), .arst_n(arst_n), .req(req), .cmd(cmd), .sts(sts), .res(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			out_q <= '0;
		end else if (done) begin
			out_vld_q <= 1'b1;
			out_q <= {5'd0, res.collected, res.last_tick_out, res.pinned_out,
				res.complete, res.object_length_out, res.packet_total_out,
				res.accepted_count, res.slot_address, res.entry_no, res.ok};
		end else if (m_axis_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata = out_q;
endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
module tb;
	localparam int ENTRIES = oprc_pkg::ENTRIES;
	localparam int SLOTS = oprc_pkg::SLOTS;
	localparam logic [1:0] ACT_STORE = oprc_pkg::ACT_STORE;
	localparam logic [1:0] ACT_FIND = oprc_pkg::ACT_FIND;
	localparam logic [1:0] ACT_PIN = oprc_pkg::ACT_PIN;
	localparam logic [1:0] ACT_COLLECT = oprc_pkg::ACT_COLLECT;

	typedef struct {
		logic [1:0]  action;
		logic [63:0] w0, w1, w2, w3;
		logic [31:0] len;
		logic [15:0] total;
		logic [15:0] slot;
		logic        pkt_ok;
		logic [63:0] tick;
		logic        pin;
		logic [7:0]  limit;
	} request_t;

	typedef struct {
		logic        ok;
		logic [2:0]  entry_no;
		logic [6:0]  slot_address;
		logic [4:0]  accepted_count;
		logic [4:0]  packet_total_out;
		logic [31:0] object_length_out;
		logic        complete;
		logic        pinned_out;
		logic [63:0] last_tick_out;
		logic [3:0]  collected;
	} outcome_t;

	typedef struct {
		request_t req;
		logic     typed;
		outcome_t want;
	} row_t;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [399:0] s_axis_tdata;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [127:0] m_axis_tdata;

	logic [63:0] key0 [ENTRIES];
	logic [63:0] key1 [ENTRIES];
	logic [63:0] key2 [ENTRIES];
	logic [63:0] key3 [ENTRIES];
	logic [31:0] obj_len [ENTRIES];
	logic [4:0]  obj_total [ENTRIES];
	logic [4:0]  arrived [ENTRIES];
	logic [63:0] last_tick [ENTRIES];
	logic        pinned [ENTRIES];
	logic        done [ENTRIES];
	logic [15:0] filled [ENTRIES];

	outcome_t pending_results[$];
	row_t     directed[$];
	int       errors = 0;
	bit       quiet;
	int       stall_left = 0;

	logic [63:0] pool_w [10][4];
	logic [31:0] pool_len [10];
	logic [15:0] pool_total [10];

	object_packet_reassembly_cache i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always #10 clk = ~clk;

	initial begin
		#20ms;
		$display("Some tests failed");
		$finish;
	end

	function automatic logic [399:0] pack_request(request_t r);
		logic [399:0] d;
		d = '0;
		d[1:0] = r.action;
		d[65:2] = r.w0;
		d[129:66] = r.w1;
		d[193:130] = r.w2;
		d[257:194] = r.w3;
		d[289:258] = r.len;
		d[305:290] = r.total;
		d[321:306] = r.slot;
		d[322] = r.pkt_ok;
		d[386:323] = r.tick;
		d[387] = r.pin;
		d[395:388] = r.limit;
		return d;
	endfunction

	function automatic outcome_t unpack_outcome(logic [127:0] d);
		outcome_t o;
		o.ok = d[0];
		o.entry_no = d[3:1];
		o.slot_address = d[10:4];
		o.accepted_count = d[15:11];
		o.packet_total_out = d[20:16];
		o.object_length_out = d[52:21];
		o.complete = d[53];
		o.pinned_out = d[54];
		o.last_tick_out = d[118:55];
		o.collected = d[122:119];
		return o;
	endfunction

	function automatic outcome_t failed();
		outcome_t o;
		o = '{default: '0};
		return o;
	endfunction

	function automatic request_t make_req(logic [1:0] act, logic [63:0] w0, logic [63:0] w1,
			logic [63:0] w2, logic [63:0] w3, logic [31:0] len, logic [15:0] total,
			logic [15:0] slot, logic pkt_ok, logic [63:0] tick, logic pin, logic [7:0] limit);
		request_t r;
		r = '{act, w0, w1, w2, w3, len, total, slot, pkt_ok, tick, pin, limit};
		return r;
	endfunction

	function automatic bit entry_live(int e);
		return obj_total[e] != 0 && (key0[e] | key1[e] | key2[e] | key3[e]) != 0;
	endfunction

	function automatic void clear_entry(int e);
		key0[e] = 0; key1[e] = 0; key2[e] = 0; key3[e] = 0;
		obj_len[e] = 0; obj_total[e] = 0; arrived[e] = 0; last_tick[e] = 0;
		pinned[e] = 0; done[e] = 0; filled[e] = 0;
	endfunction

	function automatic int find_entry(request_t r);
		if ((r.w0 | r.w1 | r.w2 | r.w3) == 0)
			return ENTRIES;
		for (int e = 0; e < ENTRIES; e++)
			if (entry_live(e) && key0[e] == r.w0 && key1[e] == r.w1 && key2[e] == r.w2 &&
					key3[e] == r.w3)
				return e;
		return ENTRIES;
	endfunction

	function automatic outcome_t entry_view(int e);
		outcome_t o;
		o = failed();
		o.ok = 1;
		o.entry_no = e[2:0];
		o.accepted_count = arrived[e];
		o.packet_total_out = obj_total[e];
		o.object_length_out = obj_len[e];
		o.complete = done[e];
		o.pinned_out = pinned[e];
		o.last_tick_out = last_tick[e];
		return o;
	endfunction

	function automatic outcome_t reassembly_step(request_t r);
		outcome_t o;
		int e;
		int best;
		int count;
		o = failed();
		case (r.action)
			ACT_STORE: begin
				if (r.tick == 0 || !r.pkt_ok || (r.w0 | r.w1 | r.w2 | r.w3) == 0 ||
						r.total > SLOTS || r.slot >= r.total)
					return o;
				e = find_entry(r);
				if (e >= ENTRIES) begin
					for (e = 0; e < ENTRIES; e++)
						if (!entry_live(e))
							break;
					if (e >= ENTRIES)
						return o;
				end
				if (filled[e][r.slot[3:0]])
					return o;
				if (obj_total[e] == 0) begin
					key0[e] = r.w0; key1[e] = r.w1; key2[e] = r.w2; key3[e] = r.w3;
					obj_len[e] = r.len;
					obj_total[e] = r.total[4:0];
				end else if (obj_len[e] != r.len || obj_total[e] != r.total) begin
					return o;
				end
				filled[e][r.slot[3:0]] = 1;
				arrived[e] = arrived[e] + 5'd1;
				last_tick[e] = r.tick;
				done[e] = arrived[e] == obj_total[e];
				o = entry_view(e);
				o.slot_address = 7'(e * SLOTS + r.slot);
			end
			ACT_FIND, ACT_PIN: begin
				e = find_entry(r);
				if (e >= ENTRIES)
					return o;
				if (r.action == ACT_PIN)
					pinned[e] = r.pin;
				o = entry_view(e);
			end
			default: begin
				if (r.limit == 0)
					return o;
				count = 0;
				while (count < r.limit) begin
					best = ENTRIES;
					for (int i = 0; i < ENTRIES; i++)
						if (entry_live(i) && !pinned[i] &&
								(best >= ENTRIES || last_tick[i] < last_tick[best]))
							best = i;
					if (best >= ENTRIES)
						break;
					clear_entry(best);
					count++;
				end
				o.ok = 1;
				o.collected = 4'(count);
			end
		endcase
		return o;
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic void refresh_pool(int p);
		for (int k = 0; k < 4; k++)
			pool_w[p][k] = ($urandom_range(0, 3) == 0) ? 64'd0 : rand64();
		if (pool_w[p][0] == 0 && pool_w[p][3] == 0)
			pool_w[p][3] = rand64() | 64'd1;
		pool_len[p] = $urandom;
		pool_total[p] = 16'($urandom_range(1, SLOTS));
	endfunction

	function automatic request_t random_request();
		request_t r;
		int p;
		int pick;
		p = $urandom_range(0, 9);
		if ($urandom_range(0, 59) == 0)
			refresh_pool(p);
		pick = $urandom_range(0, 99);
		r = make_req(ACT_STORE, pool_w[p][0], pool_w[p][1], pool_w[p][2], pool_w[p][3],
			pool_len[p], pool_total[p], 16'($urandom_range(0, pool_total[p] - 1)), 1'b1,
			($urandom_range(0, 3) == 0) ? 64'($urandom_range(1, 4)) : rand64() | 64'd1,
			1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
		if (pick < 55) begin
		end else if (pick < 65) begin
			r.len = ($urandom_range(0, 1)) ? $urandom : r.len;
			r.total = ($urandom_range(0, 1)) ? 16'($urandom) : 16'($urandom_range(0, 17));
			r.slot = ($urandom_range(0, 1)) ? 16'($urandom) : 16'($urandom_range(0, 17));
			r.pkt_ok = 1'($urandom_range(0, 1));
			r.tick = ($urandom_range(0, 3) == 0) ? 64'd0 : rand64();
			if ($urandom_range(0, 3) == 0) begin
				r.w0 = rand64(); r.w1 = rand64(); r.w2 = rand64(); r.w3 = rand64();
			end
			if ($urandom_range(0, 5) == 0) begin
				r.w0 = 0; r.w1 = 0; r.w2 = 0; r.w3 = 0;
			end
		end else if (pick < 80) begin
			r.action = ACT_FIND;
		end else if (pick < 88) begin
			r.action = ACT_PIN;
		end else begin
			r.action = ACT_COLLECT;
			case ($urandom_range(0, 9))
				0: r.limit = 0;
				1: r.limit = 8'($urandom_range(0, 255));
				2: r.limit = 8'd255;
				default: r.limit = 8'($urandom_range(1, 3));
			endcase
		end
		if (r.action != ACT_STORE && $urandom_range(0, 9) == 0) begin
			r.w0 = rand64(); r.w1 = rand64(); r.w2 = rand64(); r.w3 = rand64();
		end
		return r;
	endfunction

	function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected %h, got %h", name, want, got);
			errors++;
		end
	endfunction

	always @(posedge clk) begin
		outcome_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = unpack_outcome(m_axis_tdata);
			if (pending_results.size() == 0) begin
				$error("result item with no expectation waiting");
				errors++;
			end else begin
				want = pending_results.pop_front();
				check_field("ok", want.ok, got.ok);
				check_field("entry_no", want.entry_no, got.entry_no);
				check_field("slot_address", want.slot_address, got.slot_address);
				check_field("accepted_count", want.accepted_count, got.accepted_count);
				check_field("packet_total_out", want.packet_total_out, got.packet_total_out);
				check_field("object_length_out", want.object_length_out,
					got.object_length_out);
				check_field("complete", want.complete, got.complete);
				check_field("pinned_out", want.pinned_out, got.pinned_out);
				check_field("last_tick_out", want.last_tick_out, got.last_tick_out);
				check_field("collected", want.collected, got.collected);
			end
		end
	end

	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_axis_tready <= 1'b0;
		end else if (!quiet && $urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(0, 10);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	task automatic push_row(request_t r, logic typed, outcome_t want);
		row_t row;
		row.req = r;
		row.typed = typed;
		row.want = want;
		directed.push_back(row);
	endtask

	task automatic build_directed();
		logic [63:0] ones;
		ones = '1;
		push_row(make_req(ACT_FIND, ones, ones, ones, ones, 0, 0, 0, 0, 0, 0, 0), 1, failed());
		push_row(make_req(ACT_COLLECT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, failed());
		push_row(make_req(ACT_STORE, 1, 2, 3, 4, 9, 4, 0, 1, 0, 0, 0), 1, failed());
		push_row(make_req(ACT_STORE, 1, 2, 3, 4, 9, 4, 0, 0, 5, 0, 0), 1, failed());
		push_row(make_req(ACT_STORE, 0, 0, 0, 0, 9, 4, 0, 1, 5, 0, 0), 1, failed());
		push_row(make_req(ACT_STORE, 1, 2, 3, 4, 9, 17, 0, 1, 5, 0, 0), 1, failed());
		push_row(make_req(ACT_STORE, 1, 2, 3, 4, 9, 16'hffff, 0, 1, 5, 0, 0), 1, failed());
		push_row(make_req(ACT_STORE, 1, 2, 3, 4, 9, 0, 0, 1, 5, 0, 0), 1, failed());
		push_row(make_req(ACT_STORE, 1, 2, 3, 4, 9, 4, 4, 1, 5, 0, 0), 1, failed());
		push_row(make_req(ACT_STORE, ones, ones, ones, ones, '1, 16, 15, 1, ones, 1, '1),
			0, failed());
		push_row(make_req(ACT_STORE, ones, ones, ones, ones, '1, 16, 15, 1, 7, 0, 0), 1,
			failed());
		push_row(make_req(ACT_STORE, ones, ones, ones, ones, 5, 16, 0, 1, 7, 0, 0), 1,
			failed());
		push_row(make_req(ACT_STORE, ones, ones, ones, ones, '1, 15, 0, 1, 7, 0, 0), 1,
			failed());
		push_row(make_req(ACT_STORE, 0, 0, 0, 1, 0, 1, 0, 1, 3, 0, 0), 0, failed());
		push_row(make_req(ACT_STORE, 1, 2, 3, 4, 9, 2, 1, 1, 3, 0, 0), 0, failed());
		push_row(make_req(ACT_STORE, 1, 2, 3, 4, 9, 2, 0, 1, 8, 0, 0), 0, failed());
		push_row(make_req(ACT_FIND, ones, ones, ones, ones, 0, 0, 0, 0, 0, 0, 0), 0, failed());
		push_row(make_req(ACT_PIN, ones, ones, ones, ones, 0, 0, 0, 0, 0, 1, 0), 0, failed());
		push_row(make_req(ACT_PIN, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0), 1, failed());
		push_row(make_req(ACT_PIN, 0, 0, 0, 1, 0, 0, 0, 0, 0, 1, 0), 0, failed());
		push_row(make_req(ACT_COLLECT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1), 0, failed());
		push_row(make_req(ACT_PIN, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0), 0, failed());
		push_row(make_req(ACT_COLLECT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 255), 0, failed());
		push_row(make_req(ACT_FIND, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0), 1, failed());
	endtask

	task automatic accept(request_t r, logic typed, outcome_t want);
		outcome_t predicted;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= pack_request(r);
		do
			@(posedge clk);
		while (!s_axis_tready);
		predicted = reassembly_step(r);
		pending_results.push_back(typed ? want : predicted);
	endtask

	task automatic maybe_gap();
		if (!quiet && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
	endtask

	initial begin
		int n;
		clk = 0;
		arst_n = 0;
		s_axis_tvalid = 0;
		s_axis_tdata = '0;
		quiet = 0;
		for (int e = 0; e < ENTRIES; e++)
			clear_entry(e);
		for (int p = 0; p < 10; p++)
			refresh_pool(p);
		build_directed();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed[i]) begin
			maybe_gap();
			accept(directed[i].req, directed[i].typed, directed[i].want);
		end
		n = 1100;
		for (int i = 0; i < n; i++) begin
			if (i == n / 2) begin
				s_axis_tvalid <= 1'b0;
				while (pending_results.size() != 0)
					@(posedge clk);
			end
			if (i == n - 150)
				quiet = 1;
			maybe_gap();
			accept(random_request(), 0, failed());
		end
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule

// File: files.f
design/oprc_pkg.sv
design/oprc_ctrl.sv
design/oprc_dp.sv
design/object_packet_reassembly_cache.sv
tb/sv/tb.sv
